### hw/rtl/dwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_pkg: shared types and constants for the wildcard name matcher
// Character codes, field sizes, the name snapshot passed from the front end
// to the compare stage, and the ASCII uppercase helper.
// ----------------------------------------------------------------------------
package dwm_pkg;

  // Character codes
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharQmark = 8'h3F;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharSpace = 8'h20;

  // Name geometry
  localparam int NameLen    = 8;
  localparam int ExtLen     = 3;
  localparam int CharCountW = $clog2(NameLen + 1);
  localparam int HeadIdxW   = $clog2(NameLen);
  localparam int ExtCountW  = $clog2(ExtLen + 1);
  localparam int ExtIdxW    = $clog2(ExtLen);

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgPatternName = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatternExt  = 2'd1;

  localparam logic [NameLen-1:0][7:0] PatternNameReset = {NameLen{CharSpace}};
  localparam logic [ExtLen-1:0][7:0]  PatternExtReset  = {ExtLen{CharSpace}};

  // Queue between front end and compare stage
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCountW    = $clog2(QueueDepth + 1);

  // Completed name: space padded, uppercased, char 0 at index 0
  typedef struct packed {
    logic [ExtLen-1:0][7:0]  ext;
    logic [NameLen-1:0][7:0] name;
  } snap_t;

  typedef struct packed {
    logic  valid;
    snap_t snap;
  } push_t;

  // Uppercase ASCII letters only
  function automatic logic [7:0] to_upper(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

### hw/rtl/dwm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_front: character intake and name buffer
// Takes one character per cycle unless the queue is full, tracks name head,
// latest dot and extension, and on the last character pushes a padded, uppercased snapshot.
// ----------------------------------------------------------------------------
module dwm_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     ch_i,
  input  logic           last_i,
  output dwm_pkg::push_t push_o,
  input  logic           q_full_i
);
  import dwm_pkg::*;

  logic [7:0]            head_q [NameLen];
  logic [7:0]            ext_q  [ExtLen];
  logic [CharCountW-1:0] char_count_q, char_count_d;
  logic [CharCountW-1:0] dot_pos_q, dot_pos_d;
  logic [ExtCountW-1:0]  ext_count_q, ext_count_d;
  logic                  saw_dot_q, saw_dot_d;

  logic [7:0]            head_n [NameLen];
  logic [7:0]            ext_n  [ExtLen];
  logic [CharCountW-1:0] cc_n, dot_pos_n, nlen;
  logic [ExtCountW-1:0]  ec_n;
  logic                  saw_dot_n;
  logic                  accept;

  // Stall only when the queue has no room
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Fold the incoming character into the buffer
  always_comb begin
    head_n    = head_q;
    ext_n     = ext_q;
    cc_n      = char_count_q;
    dot_pos_n = dot_pos_q;
    ec_n      = ext_count_q;
    saw_dot_n = saw_dot_q;
    if (ch_i == CharDot) begin
      saw_dot_n = 1'b1;
      dot_pos_n = char_count_q;
      ec_n      = '0;
    end else if (saw_dot_q && ext_count_q < ExtCountW'(ExtLen)) begin
      ext_n[ext_count_q[ExtIdxW-1:0]] = ch_i;
      ec_n = ext_count_q + 1'b1;
    end
    if (char_count_q < CharCountW'(NameLen)) begin
      head_n[char_count_q[HeadIdxW-1:0]] = ch_i;
      cc_n = char_count_q + 1'b1;
    end
  end

  // Build the padded snapshot from the updated buffer
  assign nlen = saw_dot_n ? dot_pos_n : cc_n;

  always_comb begin
    push_o.valid = accept && last_i;
    for (int i = 0; i < NameLen; i++) begin
      push_o.snap.name[i] = (CharCountW'(i) < nlen) ? to_upper(head_n[i]) : CharSpace;
    end
    for (int i = 0; i < ExtLen; i++) begin
      push_o.snap.ext[i] = (saw_dot_n && ExtCountW'(i) < ec_n) ? to_upper(ext_n[i])
                                                                 : CharSpace;
    end
  end

  // Advance counters, clear after a completed name
  always_comb begin
    char_count_d = char_count_q;
    dot_pos_d    = dot_pos_q;
    ext_count_d  = ext_count_q;
    saw_dot_d    = saw_dot_q;
    if (accept) begin
      if (last_i) begin
        char_count_d = '0;
        dot_pos_d    = '0;
        ext_count_d  = '0;
        saw_dot_d    = 1'b0;
      end else begin
        char_count_d = cc_n;
        dot_pos_d    = dot_pos_n;
        ext_count_d  = ec_n;
        saw_dot_d    = saw_dot_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      dot_pos_q    <= '0;
      ext_count_q  <= '0;
      saw_dot_q    <= 1'b0;
    end else begin
      char_count_q <= char_count_d;
      dot_pos_q    <= dot_pos_d;
      ext_count_q  <= ext_count_d;
      saw_dot_q    <= saw_dot_d;
    end
  end

  // Character storage needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      head_q <= head_n;
      ext_q  <= ext_n;
    end
  end

endmodule

### hw/rtl/dwm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_queue: snapshot queue between front end and compare stage
// Small FIFO of completed names so intake and result delivery stall apart.
// ----------------------------------------------------------------------------
module dwm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dwm_pkg::push_t push_i,
  output logic           full_o,
  input  logic           pop_i,
  output dwm_pkg::snap_t head_o,
  output logic           empty_o
);
  import dwm_pkg::*;

  snap_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]   wptr_q, wptr_d;
  logic [QPtrW-1:0]   rptr_q, rptr_d;
  logic [QCountW-1:0] count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == QCountW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.snap;
    end
  end

  // Occupancy stays in range, and neither side overruns the queue
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCountW'(QueueDepth))
    else $error("queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

### hw/rtl/dwm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwm_back: pattern registers and wildcard compare
// Holds the pattern, compares the queue head against it and registers the
// match bit for the output channel.
// ----------------------------------------------------------------------------
module dwm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [dwm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i,
  input  dwm_pkg::snap_t              head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        match_o
);
  import dwm_pkg::*;

  logic [NameLen-1:0][7:0] pname_q;
  logic [ExtLen-1:0][7:0]  pext_q;
  logic                    out_valid_q, out_valid_d;
  logic                    match_q;
  logic                    name_ok, ext_ok;
  logic                    star_n, star_e;
  logic [7:0]              w;

  // Write pattern registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pname_q <= PatternNameReset;
      pext_q  <= PatternExtReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPatternName: pname_q <= cfg_data_i;
        CfgPatternExt:  pext_q  <= cfg_data_i[8*ExtLen-1:0];
        default: ;
      endcase
    end
  end

  // Compare each part up to its first star
  always_comb begin
    name_ok = 1'b1;
    ext_ok  = 1'b1;
    star_n  = 1'b0;
    star_e  = 1'b0;
    w       = '0;
    for (int i = 0; i < NameLen; i++) begin
      w = to_upper(pname_q[i]);
      if (w == CharStar) star_n = 1'b1;
      if (!star_n && w != CharQmark && w != head_i.name[i]) name_ok = 1'b0;
    end
    for (int i = 0; i < ExtLen; i++) begin
      w = to_upper(pext_q[i]);
      if (w == CharStar) star_e = 1'b1;
      if (!star_e && w != CharQmark && w != head_i.ext[i]) ext_ok = 1'b0;
    end
  end

  // Pop when the output register is free or being taken
  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      match_q <= name_ok && ext_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign match_o     = match_q;

endmodule

### hw/rtl/dos_wildcard_name_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dos_wildcard_name_match: streaming DOS 8.3 wildcard file name matcher
// Usage:
//   Input channel (in_valid_i / in_stall_o): one name character per item in
//   ch_i, with last_i set on the final character. One item per cycle is
//   taken; in_stall_o rises only while the two-entry name queue is full.
//   Output channel (out_valid_o / out_stall_i): one match_o item per name,
//   passed through the name queue and then held in the registered output.
//   Names without their last character yet produce nothing.
//   Config channel (cfg_valid_i / cfg_ready_o, always ready): index 0 writes
//   the eight pattern name characters, index 1 the three extension
//   characters (low 24 bits), char 0 in the low byte, space padded. Other
//   indexes are ignored. Write only while no name is in flight.
//   Throughput is one character per cycle while in_stall_o is low, set by the
//   combinational buffer fold in the front end and combinational compare in the back end.
//   While the receiver stalls, the result holds in its output register, the
//   queue absorbs two more names, then the input stalls.
//   Reset empties the queue, clears the name buffer counters and sets both pattern
//   registers to all spaces.
// ----------------------------------------------------------------------------
module dos_wildcard_name_match (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  ch_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        match_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dwm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                 cfg_data_i
);
  import dwm_pkg::*;

  push_t push;
  snap_t head;
  logic  q_full, q_empty, pop;

  assign cfg_ready_o = 1'b1;

  dwm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .last_i     (last_i),
    .push_o     (push),
    .q_full_i   (q_full)
  );

  dwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty)
  );

  dwm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .match_o     (match_o)
  );

endmodule
